>>> rtl/gpci_pkg.sv
`default_nettype none

package gpci_pkg;

    localparam int PORT_WIDTH = 8;
    localparam int BIT_INDEX_WIDTH = 3;

    localparam logic [PORT_WIDTH-1:0] CHANGE_PINS = 8'hf0;
    localparam logic [PORT_WIDTH-1:0] DIR_RESET = 8'hff;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EDGE_RISING = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXTERNAL_MASK = 1'b1;

    typedef enum logic [1:0] {
        OP_READ       = 2'd0,
        OP_WRITE_PORT = 2'd1,
        OP_WRITE_DIR  = 2'd2,
        OP_SET_PIN    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        opcode;
        logic [PORT_WIDTH-1:0]      data;
        logic [BIT_INDEX_WIDTH-1:0] bit_index;
        logic                       bit_level;
        logic [PORT_WIDTH-1:0]      pin_levels;
    } item_t;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] port_value;
        logic [PORT_WIDTH-1:0] output_latch;
        logic [PORT_WIDTH-1:0] direction;
    } state_t;

    typedef struct packed {
        logic                  edge_rising;
        logic [PORT_WIDTH-1:0] external_mask;
    } cfg_t;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] read_data;
        logic                  edge_irq;
        logic                  change_irq;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/gpci_core.sv
`default_nettype none

module gpci_core
(
    input  wire gpci_pkg::item_t   item,
    input  wire gpci_pkg::state_t  state,
    input  wire gpci_pkg::cfg_t    cfg,
    output gpci_pkg::state_t       state_next,
    output gpci_pkg::result_t      result
);

    logic [gpci_pkg::PORT_WIDTH-1:0] port_next;
    logic [gpci_pkg::PORT_WIDTH-1:0] set_value;
    logic [gpci_pkg::PORT_WIDTH-1:0] diff;
    logic                            check_flags;
    logic                            edge_hit;
    logic                            change_hit;

    always_comb
    begin
        set_value = state.port_value;
        set_value[item.bit_index] = item.bit_level;
    end

    always_comb
    begin
        state_next = state;
        check_flags = 1'b0;
        case (item.opcode)
            gpci_pkg::OP_READ:
            begin
                state_next.port_value = (state.port_value & ~cfg.external_mask)
                                      | (item.pin_levels & cfg.external_mask);
                check_flags = 1'b1;
            end
            gpci_pkg::OP_WRITE_PORT:
            begin
                state_next.output_latch = item.data;
                state_next.port_value = item.data;
            end
            gpci_pkg::OP_WRITE_DIR:
            begin
                state_next.direction = item.data;
                state_next.port_value = state.output_latch;
            end
            gpci_pkg::OP_SET_PIN:
            begin
                state_next.port_value = set_value;
                check_flags = 1'b1;
            end
            default:
            begin
                state_next = state;
                check_flags = 1'b0;
            end
        endcase
    end

    assign port_next = state_next.port_value;
    assign diff = state.port_value ^ port_next;

    // rising edge: bit 0 was low, falling: bit 0 was high
    assign edge_hit = diff[0] & (cfg.edge_rising ? ~state.port_value[0] : state.port_value[0]);
    assign change_hit = |(diff & gpci_pkg::CHANGE_PINS & state.direction);

    always_comb
    begin
        result.read_data = port_next;
        result.edge_irq = check_flags & edge_hit;
        result.change_irq = check_flags & change_hit;
    end

endmodule

`default_nettype wire

>>> rtl/gpio_port_change_interrupt.sv
// path: an accepted item enters the input register, its result then the result register
// throughput: one item per cycle while the receiver does not stall
// port state updates at the same edge as the result register
// a waiting result blocks a new transfer only while the input register is also full
// reset: port value and output latch zero, every pin an input, edge_rising = 1,
// external_mask = 0, both pipeline registers empty
`default_nettype none

module gpio_port_change_interrupt
(
    input  wire                                     clk,
    input  wire                                     rst_n,

    input  wire                                     cfg_write,
    input  wire [gpci_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire [gpci_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,

    input  wire                                     in_valid,
    output logic                                    in_stall,
    input  wire [1:0]                               opcode,
    input  wire [gpci_pkg::PORT_WIDTH-1:0]          data,
    input  wire [gpci_pkg::BIT_INDEX_WIDTH-1:0]     bit_index,
    input  wire                                     bit_level,
    input  wire [gpci_pkg::PORT_WIDTH-1:0]          pin_levels,

    output logic                                    out_valid,
    input  wire                                     out_stall,
    output logic [gpci_pkg::PORT_WIDTH-1:0]         read_data,
    output logic                                    edge_irq,
    output logic                                    change_irq
);

    gpci_pkg::cfg_t    cfg_reg;
    gpci_pkg::state_t  state_reg;
    gpci_pkg::state_t  state_next;
    gpci_pkg::item_t   item_reg;
    gpci_pkg::item_t   item_next;
    logic              item_valid_reg;
    gpci_pkg::result_t result_reg;
    gpci_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              out_ready;
    logic              advance;
    logic              in_take;

    assign out_ready = ~out_valid_reg | ~out_stall;
    assign advance = item_valid_reg & out_ready;
    assign in_stall = item_valid_reg & ~out_ready;
    assign in_take = in_valid & ~in_stall;

    always_comb
    begin
        item_next.opcode = gpci_pkg::op_t'(opcode);
        item_next.data = data;
        item_next.bit_index = bit_index;
        item_next.bit_level = bit_level;
        item_next.pin_levels = pin_levels;
    end

    gpci_core u_core
    (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_rising <= 1'b1;
            cfg_reg.external_mask <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gpci_pkg::CFG_EDGE_RISING:   cfg_reg.edge_rising <= cfg_data[0];
                gpci_pkg::CFG_EXTERNAL_MASK: cfg_reg.external_mask <= cfg_data;
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.port_value <= '0;
            state_reg.output_latch <= '0;
            state_reg.direction <= gpci_pkg::DIR_RESET;
            item_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (~out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = result_reg.read_data;
    assign edge_irq = result_reg.edge_irq;
    assign change_irq = result_reg.change_irq;

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

    import gpci_pkg::*;

    localparam int LIMIT = 300000;
    localparam int PHASE_ITEMS = 200;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]   cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]    cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    op_t                          opcode = OP_READ;
    logic [PORT_WIDTH-1:0]        data = '0;
    logic [BIT_INDEX_WIDTH-1:0]   bit_index = '0;
    logic                         bit_level = 1'b0;
    logic [PORT_WIDTH-1:0]        pin_levels = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [PORT_WIDTH-1:0]        read_data;
    logic                         edge_irq;
    logic                         change_irq;

    // predicted port state and register copies
    logic [PORT_WIDTH-1:0]        port_q = '0;
    logic [PORT_WIDTH-1:0]        latch_q = '0;
    logic [PORT_WIDTH-1:0]        dir_q = DIR_RESET;
    logic                         edge_rising_q = 1'b1;
    logic [PORT_WIDTH-1:0]        ext_mask_q = '0;

    result_t                      port_expected[$];
    result_t                      want;
    int                           errors = 0;
    int                           cycles = 0;
    int                           sent = 0;
    int                           settings = 0;
    int                           edge_count = 0;
    int                           change_count = 0;
    int                           gap_pct = 0;
    int                           stall_pct = 0;
    int                           stall_hold = 0;

    gpio_port_change_interrupt u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .data       (data),
        .bit_index  (bit_index),
        .bit_level  (bit_level),
        .pin_levels (pin_levels),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .edge_irq   (edge_irq),
        .change_irq (change_irq)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycles, port_expected.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls: mostly single cycles, now and then a long stretch
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            out_stall <= 1'b1;
            stall_hold <= stall_hold - 1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_stall <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                stall_hold <= $urandom_range(8, 40);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (port_expected.size() == 0)
            begin
                $display("%0t: unexpected result read_data=%h edge_irq=%b change_irq=%b",
                         $time, read_data, edge_irq, change_irq);
                errors++;
            end
            else
            begin
                want = port_expected.pop_front();
                if (read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, read_data);
                    errors++;
                end
                if (edge_irq !== want.edge_irq)
                begin
                    $display("%0t: edge_irq expected %b actual %b",
                             $time, want.edge_irq, edge_irq);
                    errors++;
                end
                if (change_irq !== want.change_irq)
                begin
                    $display("%0t: change_irq expected %b actual %b",
                             $time, want.change_irq, change_irq);
                    errors++;
                end
            end
        end
    end

    function automatic logic [PORT_WIDTH-1:0] rand_byte();
        return PORT_WIDTH'($urandom);
    endfunction

    function automatic logic [BIT_INDEX_WIDTH-1:0] rand_index();
        return BIT_INDEX_WIDTH'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom);
    endfunction

    function automatic result_t port_predict(item_t it);
        result_t               r;
        logic [PORT_WIDTH-1:0] prior;
        logic [PORT_WIDTH-1:0] diff;
        prior = port_q;
        r = '0;
        case (it.opcode)
            OP_READ:
                port_q = (port_q & ~ext_mask_q) | (it.pin_levels & ext_mask_q);
            OP_WRITE_PORT:
            begin
                latch_q = it.data;
                port_q = it.data;
            end
            OP_WRITE_DIR:
            begin
                dir_q = it.data;
                port_q = latch_q;
            end
            default:
                port_q[it.bit_index] = it.bit_level;
        endcase
        if (it.opcode == OP_READ || it.opcode == OP_SET_PIN)
        begin
            diff = prior ^ port_q;
            r.edge_irq = diff[0] && (edge_rising_q ? !prior[0] : prior[0]);
            r.change_irq = |(diff & CHANGE_PINS & dir_q);
        end
        r.read_data = port_q;
        return r;
    endfunction

    function automatic int pick_gap();
        if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic item_t make_item(op_t op, logic [PORT_WIDTH-1:0] d,
                                        logic [BIT_INDEX_WIDTH-1:0] idx, logic lvl,
                                        logic [PORT_WIDTH-1:0] pins);
        item_t it;
        it.opcode = op;
        it.data = d;
        it.bit_index = idx;
        it.bit_level = lvl;
        it.pin_levels = pins;
        return it;
    endfunction

    function automatic item_t random_op();
        item_t it;
        int    pick;
        int    sel;
        pick = $urandom_range(0, 9);
        sel = $urandom_range(0, 9);
        it.data = rand_byte();
        it.bit_index = rand_index();
        it.bit_level = rand_bit();
        it.pin_levels = rand_byte();
        if (pick < 4)
            it.opcode = OP_READ;
        else if (pick == 4)
            it.opcode = OP_WRITE_PORT;
        else if (pick == 5)
            it.opcode = OP_WRITE_DIR;
        else
            it.opcode = OP_SET_PIN;
        // steer toward single-pin toggles and the pins that raise interrupts
        if (it.opcode == OP_READ && sel < 4)
            it.pin_levels = port_q ^ (8'h01 << $urandom_range(0, 7));
        if (it.opcode == OP_SET_PIN && sel < 5)
            it.bit_index = (sel < 2) ? '0 : BIT_INDEX_WIDTH'($urandom_range(4, 7));
        if (it.opcode == OP_WRITE_DIR && sel < 3)
            it.data = (sel == 0) ? 8'hff : (sel == 1) ? 8'h00 : 8'hf0;
        return it;
    endfunction

    task automatic send_item(item_t it);
        int      gap;
        result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= it.opcode;
        data <= it.data;
        bit_index <= it.bit_index;
        bit_level <= it.bit_level;
        pin_levels <= it.pin_levels;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = port_predict(it);
        port_expected.push_back(r);
        sent++;
        edge_count += int'(r.edge_irq);
        change_count += int'(r.change_irq);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (port_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_EDGE_RISING)
            edge_rising_q = val[0];
        else
            ext_mask_q = val;
        @(posedge clk);
    endtask

    task automatic set_config(logic rising, logic [PORT_WIDTH-1:0] mask);
        drain();
        write_reg(CFG_EDGE_RISING, {7'($urandom), rising});
        write_reg(CFG_EXTERNAL_MASK, mask);
        settings++;
    endtask

    task automatic test_after_reset();
        send_item(make_item(OP_READ, rand_byte(), rand_index(), rand_bit(), 8'hff));
        send_item(make_item(OP_SET_PIN, rand_byte(), 3'd0, 1'b1, rand_byte()));
        send_item(make_item(OP_SET_PIN, rand_byte(), 3'd7, 1'b1, rand_byte()));
        send_item(make_item(OP_SET_PIN, rand_byte(), 3'd7, 1'b0, rand_byte()));
    endtask

    task automatic test_port_writes();
        send_item(make_item(OP_WRITE_PORT, 8'hff, rand_index(), rand_bit(), rand_byte()));
        send_item(make_item(OP_WRITE_PORT, 8'h00, rand_index(), rand_bit(), rand_byte()));
        send_item(make_item(OP_WRITE_DIR, 8'h0f, rand_index(), rand_bit(), rand_byte()));
        // output pins on the upper nibble never raise a change interrupt
        send_item(make_item(OP_SET_PIN, rand_byte(), 3'd5, 1'b1, rand_byte()));
        send_item(make_item(OP_SET_PIN, rand_byte(), 3'd0, 1'b1, rand_byte()));
        send_item(make_item(OP_SET_PIN, rand_byte(), 3'd0, 1'b0, rand_byte()));
        send_item(make_item(OP_WRITE_DIR, 8'h00, rand_index(), rand_bit(), rand_byte()));
        send_item(make_item(OP_WRITE_PORT, 8'ha5, rand_index(), rand_bit(), rand_byte()));
        send_item(make_item(OP_WRITE_DIR, 8'hff, rand_index(), rand_bit(), rand_byte()));
    endtask

    task automatic test_falling_edge();
        set_config(1'b0, 8'hff);
        send_item(make_item(OP_READ, rand_byte(), rand_index(), rand_bit(), 8'hff));
        send_item(make_item(OP_READ, rand_byte(), rand_index(), rand_bit(), 8'h00));
        send_item(make_item(OP_READ, rand_byte(), rand_index(), rand_bit(), 8'h01));
        send_item(make_item(OP_READ, rand_byte(), rand_index(), rand_bit(), 8'h10));
        send_item(make_item(OP_SET_PIN, rand_byte(), 3'd0, 1'b0, rand_byte()));
    endtask

    task automatic test_external_mask();
        set_config(1'b1, 8'h81);
        send_item(make_item(OP_READ, rand_byte(), rand_index(), rand_bit(), 8'h7e));
        send_item(make_item(OP_READ, rand_byte(), rand_index(), rand_bit(), 8'hff));
        send_item(make_item(OP_READ, rand_byte(), rand_index(), rand_bit(), 8'h00));
    endtask

    task automatic test_random_traffic();
        logic [PORT_WIDTH-1:0] masks [8];
        int                    gaps [8];
        int                    stalls [8];
        masks = '{8'h00, 8'hff, 8'hff, 8'hf1, 8'h00, 8'h00, 8'h00, 8'h00};
        gaps = '{0, 10, 30, 60, 0, 10, 30, 5};
        stalls = '{0, 10, 30, 60, 30, 0, 60, 5};
        for (int p = 0; p < 8; p++)
        begin
            if (p >= 4)
                masks[p] = rand_byte();
            set_config((p < 4) ? p[0] ^ 1'b1 : rand_bit(), masks[p]);
            gap_pct = gaps[p];
            stall_pct = stalls[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_op());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settings = 1;
        test_after_reset();
        test_port_writes();
        test_falling_edge();
        test_external_mask();
        test_random_traffic();
        drain();
        $display("%0d transfers checked across %0d register settings", sent, settings);
        $display("%0d edge and %0d change interrupts predicted", edge_count, change_count);
        if (errors == 0 && port_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
